// ----- rtl/sfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpd_pkg: shared constants for the serial frame parser
// Frame delimiters, reset values of the held target and configuration
// register indexes used by the frame parser and its dispatch logic.
// ----------------------------------------------------------------------------
package sfpd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [7:0] FRAME_END  = 8'h5D;

  localparam logic [7:0] LAND_X_RESET = 8'd80;
  localparam logic [7:0] LAND_Y_RESET = 8'd60;

  localparam int unsigned CODE_COUNT = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned MATCH_W    = 3;

  // Configuration register indexes, also the match index of each code.
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_HEIGHT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_POSITION    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SEARCH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LANDING     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_RANGES_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_RANGES_HIGH = 3'd5;
  localparam logic [MATCH_W-1:0]   MATCH_NONE           = 3'd6;

  typedef logic [7:0] byte_t;
  typedef byte_t [3:0] payload_t;

endpackage

// ----- rtl/serial_frame_parser_dispatch.sv -----
// ----------------------------------------------------------------------------
// serial_frame_parser_dispatch: fixed-length serial frame parser
// Recognizes frames AA 55 <cmd> <p0> <p1> <p2> <p3> 5D in a byte stream,
// matches the command against six programmable codes and updates the held
// values, then reports the match index together with every held value.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   -------   ---------  --------------------  ---------------------------------
//   in        sink       in_valid_i/in_ready_o byte_in_i
//   out       source     out_valid_o/out_ready_i matched_command_o, held values
//   cfg       sink       cfg_we_i (no wait)    cfg_index_i, cfg_wdata_i
//
// Every byte is handled in the cycle it is accepted, and a new frame can begin
// before a result is taken. A request leaves in the cycle after its footer.
// Reset clears the parser, restores the default command codes and the held
// values; the payload buffer is not reset. The input stalls only when the
// footer byte is due while an earlier result still waits at the output;
// every other byte is taken even while the output is stalled.
// ----------------------------------------------------------------------------
module serial_frame_parser_dispatch (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [sfpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_wdata_i,
  // Byte stream.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    byte_in_i,
  // Frame results.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sfpd_pkg::MATCH_W-1:0]  matched_command_o,
  output logic [15:0]                   height_o,
  output logic [15:0]                   pos_x_o,
  output logic [15:0]                   pos_y_o,
  output logic [7:0]                    search_char_o,
  output logic [7:0]                    search_num_o,
  output logic [7:0]                    land_x_o,
  output logic [7:0]                    land_y_o,
  output logic [15:0]                   range_0_o,
  output logic [15:0]                   range_1_o,
  output logic [15:0]                   range_2_o,
  output logic [15:0]                   range_3_o
);
  import sfpd_pkg::*;

  // Parser phases. Unused encodings behave like hunting.
  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_SECOND = 3'd1;
  localparam logic [2:0] PH_CMD    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_FOOTER = 3'd4;

  logic [2:0]   phase_q, phase_d;
  byte_t        command_q, command_d;
  logic [1:0]   count_q, count_d;
  payload_t     payload_q;
  byte_t        codes_q [CODE_COUNT];

  logic [15:0]  height_q, height_d;
  logic [15:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  byte_t        search_char_q, search_char_d, search_num_q, search_num_d;
  byte_t        land_x_q, land_x_d, land_y_q, land_y_d;
  logic [15:0]  range_0_q, range_0_d, range_1_q, range_1_d;
  logic [15:0]  range_2_q, range_2_d, range_3_q, range_3_d;

  logic [MATCH_W-1:0] match_q, match_d;
  logic               out_valid_q, out_valid_d;

  logic         in_fire;
  logic         frame_done;
  logic         payload_we;
  logic [MATCH_W-1:0] hit;
  logic [15:0]  word_lo, word_hi;

  // A result can only be produced by the footer byte, so every other byte
  // is accepted regardless of the output side.
  assign in_ready_o = (phase_q != PH_FOOTER) || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign frame_done = in_fire && (phase_q == PH_FOOTER) && (byte_in_i == FRAME_END);
  assign payload_we = in_fire && (phase_q == PH_DATA);

  // Parser state machine.
  always_comb begin
    phase_d   = phase_q;
    command_d = command_q;
    count_d   = count_q;
    if (in_fire) begin
      unique case (phase_q)
        PH_SECOND: begin
          phase_d = (byte_in_i == HDR_SECOND) ? PH_CMD : PH_HUNT;
        end
        PH_CMD: begin
          command_d = byte_in_i;
          count_d   = 2'd0;
          phase_d   = PH_DATA;
        end
        PH_DATA: begin
          count_d = count_q + 2'd1;
          if (count_q == 2'd3) begin
            phase_d = PH_FOOTER;
          end
        end
        PH_FOOTER: begin
          count_d = 2'd0;
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = (byte_in_i == HDR_FIRST) ? PH_SECOND : PH_HUNT;
        end
      endcase
    end
  end

  // Priority match: the lowest-numbered equal code wins.
  always_comb begin
    hit = MATCH_NONE;
    for (int k = CODE_COUNT - 1; k >= 0; k--) begin
      if (codes_q[k] == command_q) begin
        hit = MATCH_W'(k);
      end
    end
  end

  // Payload bytes are big-endian pairs.
  assign word_lo = {payload_q[0], payload_q[1]};
  assign word_hi = {payload_q[2], payload_q[3]};

  always_comb begin
    height_d      = height_q;
    pos_x_d       = pos_x_q;
    pos_y_d       = pos_y_q;
    search_char_d = search_char_q;
    search_num_d  = search_num_q;
    land_x_d      = land_x_q;
    land_y_d      = land_y_q;
    range_0_d     = range_0_q;
    range_1_d     = range_1_q;
    range_2_d     = range_2_q;
    range_3_d     = range_3_q;
    match_d       = match_q;
    if (frame_done) begin
      match_d = hit;
      unique case (hit)
        CFG_CODE_HEIGHT: begin
          height_d = word_lo;
        end
        CFG_CODE_POSITION: begin
          pos_x_d = word_lo;
          pos_y_d = word_hi;
        end
        CFG_CODE_SEARCH: begin
          search_char_d = payload_q[0];
          search_num_d  = payload_q[1];
        end
        CFG_CODE_LANDING: begin
          land_x_d = payload_q[0];
          land_y_d = payload_q[1];
        end
        CFG_CODE_RANGES_LOW: begin
          range_0_d = word_lo;
          range_1_d = word_hi;
        end
        CFG_CODE_RANGES_HIGH: begin
          range_2_d = word_lo;
          range_3_d = word_hi;
        end
        default: begin
        end
      endcase
    end
  end

  // The held values are not touched while a result waits, except at the edge
  // where that result is taken, so they can drive the outputs directly.
  always_comb begin
    out_valid_d = out_valid_q;
    if (frame_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      command_q     <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      match_q       <= MATCH_NONE;
      height_q      <= '0;
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      search_char_q <= '0;
      search_num_q  <= '0;
      land_x_q      <= LAND_X_RESET;
      land_y_q      <= LAND_Y_RESET;
      range_0_q     <= '0;
      range_1_q     <= '0;
      range_2_q     <= '0;
      range_3_q     <= '0;
    end else begin
      phase_q       <= phase_d;
      command_q     <= command_d;
      count_q       <= count_d;
      out_valid_q   <= out_valid_d;
      match_q       <= match_d;
      height_q      <= height_d;
      pos_x_q       <= pos_x_d;
      pos_y_q       <= pos_y_d;
      search_char_q <= search_char_d;
      search_num_q  <= search_num_d;
      land_x_q      <= land_x_d;
      land_y_q      <= land_y_d;
      range_0_q     <= range_0_d;
      range_1_q     <= range_1_d;
      range_2_q     <= range_2_d;
      range_3_q     <= range_3_d;
    end
  end

  // Command codes reset to 1..6; writes beyond the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CODE_COUNT; k++) begin
        codes_q[k] <= 8'(k + 1);
      end
    end else if (cfg_we_i) begin
      for (int k = 0; k < CODE_COUNT; k++) begin
        if (cfg_index_i == CFG_IDX_W'(k)) begin
          codes_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  // Payload buffer, always filled before the footer reads it.
  always_ff @(posedge clk_i) begin
    if (payload_we) begin
      payload_q[count_q] <= byte_in_i;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign matched_command_o = match_q;
  assign height_o          = height_q;
  assign pos_x_o           = pos_x_q;
  assign pos_y_o           = pos_y_q;
  assign search_char_o     = search_char_q;
  assign search_num_o      = search_num_q;
  assign land_x_o          = land_x_q;
  assign land_y_o          = land_y_q;
  assign range_0_o         = range_0_q;
  assign range_1_o         = range_1_q;
  assign range_2_o         = range_2_q;
  assign range_3_o         = range_3_q;

  // A correct footer always produces a request in the following cycle.
  a_footer_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> out_valid_o)
    else $error("footer byte did not produce a result");

  // Bytes outside the footer phase never change height, pos_x, range_0, range_3 or land_x.
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q != PH_FOOTER) |=>
      ($stable(height_q) && $stable(pos_x_q) && $stable(range_0_q) &&
       $stable(range_3_q) && $stable(land_x_q)))
    else $error("held value changed outside a frame end");

  // A reported match index is always a code index or the no-match value.
  a_match_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (match_q <= MATCH_NONE))
    else $error("match index out of range");

endmodule
